### rtl/itre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itre_pkg
// Types, symbol tables and digit pattern helpers for the integer to Roman
// numeral encoder.
// ----------------------------------------------------------------------------
package itre_pkg;

   localparam int VALUE_W  = 12;
   localparam int SYM_W    = 8;
   localparam int DIGIT_W  = 4;
   localparam int PLACE_W  = 2;
   localparam int POS_W    = 2;
   localparam int LEN_W    = 3;
   localparam int MULT_W   = 14;

   localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;
   localparam logic [PLACE_W-1:0] TOP_PLACE = 2'd3;

   localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
   localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
   localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
   localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
   localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
   localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
   localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
   localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;

   typedef enum logic [1:0] {
      CODE_ONE,
      CODE_FIVE,
      CODE_TEN
   } code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SPLIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic split;
      logic step_pos;
      logic dec_place;
      logic emit;
      logic emit_error;
   } cmd_type;

   typedef struct packed {
      logic value_bad;
      logic pat_empty;
      logic pos_at_end;
      logic rem_zero;
      logic place_zero;
      logic out_free;
   } status_type;

   function automatic logic [MULT_W-1:0] place_weight(input logic [PLACE_W-1:0] place);
      logic [MULT_W-1:0] w;
      case (place)
         2'd0:    w = 14'd1;
         2'd1:    w = 14'd10;
         2'd2:    w = 14'd100;
         default: w = 14'd1000;
      endcase
      return w;
   endfunction

   function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
      logic [LEN_W-1:0] n;
      case (d)
         4'd1:    n = 3'd1;
         4'd2:    n = 3'd2;
         4'd3:    n = 3'd3;
         4'd4:    n = 3'd2;
         4'd5:    n = 3'd1;
         4'd6:    n = 3'd2;
         4'd7:    n = 3'd3;
         4'd8:    n = 3'd4;
         4'd9:    n = 3'd2;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic code_type pat_code(input logic [DIGIT_W-1:0] d,
                                         input logic [POS_W-1:0]   pos);
      code_type c;
      case (d) inside
         4'd4:          c = (pos == '0) ? CODE_ONE  : CODE_FIVE;
         4'd9:          c = (pos == '0) ? CODE_ONE  : CODE_TEN;
         [4'd5:4'd8]:   c = (pos == '0) ? CODE_FIVE : CODE_ONE;
         default:       c = CODE_ONE;
      endcase
      return c;
   endfunction

   function automatic logic [SYM_W-1:0] place_sym(input logic [PLACE_W-1:0] place,
                                                  input code_type           code);
      logic [SYM_W-1:0] s;
      case (place)
         2'd0: begin
            case (code)
               CODE_ONE:  s = SYM_I;
               CODE_FIVE: s = SYM_V;
               default:   s = SYM_X;
            endcase
         end
         2'd1: begin
            case (code)
               CODE_ONE:  s = SYM_X;
               CODE_FIVE: s = SYM_L;
               default:   s = SYM_C;
            endcase
         end
         2'd2: begin
            case (code)
               CODE_ONE:  s = SYM_C;
               CODE_FIVE: s = SYM_D;
               default:   s = SYM_M;
            endcase
         end
         default: s = SYM_M;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

### rtl/itre_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itre_ctrl
// Sequencer for the encoder: takes a transaction, checks the range, then
// walks the decimal places and the characters of each digit pattern.
// ----------------------------------------------------------------------------
module itre_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  itre_pkg::status_type status,
   output itre_pkg::cmd_type    cmd
);
   import itre_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.value_bad) begin
               if (status.out_free) begin
                  cmd.emit_error = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.pat_empty) begin
               if (status.place_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.dec_place = 1'b1;
                  state_in      = ST_SPLIT;
               end
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.pos_at_end) begin
                  if (status.rem_zero || status.place_zero) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.dec_place = 1'b1;
                     state_in      = ST_SPLIT;
                  end
               end else begin
                  cmd.step_pos = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/itre_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itre_dpath
// Remainder, place and pattern position registers, digit extraction by
// parallel compare against the place multiples, and the output register.
// ----------------------------------------------------------------------------
module itre_dpath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [itre_pkg::VALUE_W-1:0]        req_value,
   input  itre_pkg::cmd_type                   cmd,
   output itre_pkg::status_type                status,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [itre_pkg::SYM_W-1:0]          rsp_symbol,
   output logic                                rsp_last,
   output logic                                rsp_error
);
   import itre_pkg::*;

   logic [VALUE_W-1:0] rem_ff;
   logic [VALUE_W-1:0] rem_in;
   logic [PLACE_W-1:0] place_ff;
   logic [PLACE_W-1:0] place_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;

   logic               valid_ff;
   logic               valid_in;
   logic [SYM_W-1:0]   symbol_ff;
   logic [SYM_W-1:0]   symbol_in;
   logic               last_ff;
   logic               last_in;
   logic               error_ff;
   logic               error_in;

   logic [MULT_W-1:0]  weight;
   logic [MULT_W-1:0]  sub;
   logic [DIGIT_W-1:0] split_digit;
   logic [LEN_W-1:0]   len;
   logic               out_free;

   assign weight   = place_weight(place_ff);
   assign len      = digit_len(digit_ff);
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      split_digit = '0;
      sub         = '0;
      for (int k = 1; k <= 9; k++) begin
         if ({{(MULT_W-VALUE_W){1'b0}}, rem_ff} >= MULT_W'(weight * MULT_W'(k))) begin
            split_digit = DIGIT_W'(k);
            sub         = MULT_W'(weight * MULT_W'(k));
         end
      end
   end

   always_comb begin
      status.value_bad  = (rem_ff == '0) || (rem_ff > MAX_VALUE);
      status.pat_empty  = (len == '0);
      status.pos_at_end = ({1'b0, pos_ff} == (len - LEN_W'(1)));
      status.rem_zero   = (rem_ff == '0);
      status.place_zero = (place_ff == '0);
      status.out_free   = out_free;
   end

   always_comb begin
      rem_in   = rem_ff;
      place_in = place_ff;
      pos_in   = pos_ff;
      digit_in = digit_ff;
      if (cmd.load) begin
         rem_in   = req_value;
         place_in = TOP_PLACE;
      end
      if (cmd.split) begin
         rem_in   = rem_ff - sub[VALUE_W-1:0];
         digit_in = split_digit;
         pos_in   = '0;
      end
      if (cmd.step_pos) begin
         pos_in = pos_ff + POS_W'(1);
      end
      if (cmd.dec_place) begin
         place_in = place_ff - PLACE_W'(1);
      end
   end

   always_comb begin
      valid_in  = valid_ff && rsp_stall;
      symbol_in = symbol_ff;
      last_in   = last_ff;
      error_in  = error_ff;
      if (cmd.emit) begin
         valid_in  = 1'b1;
         symbol_in = place_sym(place_ff, pat_code(digit_ff, pos_ff));
         last_in   = status.pos_at_end && status.rem_zero;
         error_in  = 1'b0;
      end else if (cmd.emit_error) begin
         valid_in  = 1'b1;
         symbol_in = SYM_NONE;
         last_in   = 1'b1;
         error_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      place_ff  <= place_in;
      pos_ff    <= pos_in;
      digit_ff  <= digit_in;
      symbol_ff <= symbol_in;
      last_ff   <= last_in;
      error_ff  <= error_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_symbol = symbol_ff;
   assign rsp_last   = last_ff;
   assign rsp_error  = error_ff;

endmodule
`default_nettype wire

### rtl/integer_to_roman_encoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_unit
// Converts an integer from 1 to 3999 into its Roman numeral, one ASCII
// character per result transaction, most significant first; 0 and values
// above 3999 give a single error transaction.
// Sequence: the request is accepted and the range checked; then, for each
// decimal place down to the lowest nonzero digit, the digit is split off and
// its characters are emitted in turn (none for a zero digit): 15 characters
// for the numeral 3888. A bad value gives the error transaction after the
// check. Output stalls hold the sequence; no new request is taken until done.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder_unit (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  [itre_pkg::VALUE_W-1:0]  req_value,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [itre_pkg::SYM_W-1:0]    rsp_symbol,
   output logic                          rsp_last,
   output logic                          rsp_error
);
   import itre_pkg::*;

   cmd_type    cmd;
   status_type status;

   itre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   itre_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_value),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

endmodule
`default_nettype wire
